// ===== rtl/hsw_pkg.sv =====
// Shared widths, types and helper functions for the Hermite series evaluator.
// Depends on nothing; imported by hsw_wmul and hermite_series_with_derivatives.
package hsw_pkg;

   localparam int NUM_TERMS  = 8;
   localparam int COEF_COUNT = 8;
   localparam int XW         = 32;
   localparam int CW         = 32;
   localparam int HW         = 64;
   localparam int WIDE_W     = 96;
   localparam int IDX_W      = 4;
   localparam int H_SHIFT    = 23;
   localparam int C_SHIFT    = 16;

   typedef struct packed {
      logic                            ov;
      logic [HW-1:0]                   val;
   } sat_type;

   typedef struct packed {
      logic                            valid;
      logic                            ov;
      logic [XW-1:0]                   x;
      logic [COEF_COUNT-1:0][HW-1:0]   h;
   } bundle_type;

   function automatic sat_type sat64(input logic signed [WIDE_W-1:0] v);
      sat_type r;
      if (v[WIDE_W-1:HW-1] == {(WIDE_W-HW+1){v[WIDE_W-1]}}) begin
         r.ov  = 1'b0;
         r.val = v[HW-1:0];
      end else begin
         r.ov  = 1'b1;
         r.val = v[WIDE_W-1] ? {1'b1, {(HW-1){1'b0}}} : {1'b0, {(HW-1){1'b1}}};
      end
      return r;
   endfunction

   function automatic int deriv_mult(input int q, input int k);
      int m;
      case (q)
         1:       m = 2 * k;
         2:       m = 4 * k * (k - 1);
         3:       m = 8 * k * (k - 1) * (k - 2);
         default: m = 1;
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/hsw_wmul.sv =====
// Two-stage signed 64 x 32 multiplier built from partial products of the two 32-bit halves of a.
// Depends on hsw_pkg for the operand and product widths.
module hsw_wmul
   import hsw_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [HW-1:0]     a,
   input  logic [XW-1:0]     b,
   output logic [WIDE_W-1:0] p_ff
);

   logic signed [HW-1:0] hi_ff;
   logic signed [HW:0]   lo_ff;
   logic signed [HW-1:0] hi_in;
   logic signed [HW:0]   lo_in;

   assign hi_in = $signed(a[HW-1:HW/2]) * $signed(b);
   assign lo_in = $signed({1'b0, a[HW/2-1:0]}) * $signed({{(HW/2+1-XW){b[XW-1]}}, b});

   always_ff @(posedge clock) begin
      if (en) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
         p_ff  <= (WIDE_W'(hi_ff) <<< (HW/2)) + WIDE_W'(lo_ff);
      end
   end

endmodule

// ===== rtl/hermite_series_with_derivatives.sv =====
// Top level of the pipelined Hermite series evaluator with three derivatives.
// Depends on hsw_pkg and on hsw_wmul for the recurrence and coefficient products.
//
// One sample point is accepted per clock cycle while the output is not stalled,
// and each gives one result beat. Each recurrence step costs three stages (two
// for the split 64 x 32 multiply, one to subtract and saturate), followed by one
// derivative stage, the two-stage coefficient multiply and a three-level adder
// tree. The whole pipeline holds when a finished beat is stalled at the output.
// The user must write coefficients only while the pipeline is empty; the block
// itself does not enforce this, and csr_ready is always high.
module hermite_series_with_derivatives
   import hsw_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [XW-1:0]    req_x_point,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [HW-1:0]    rsp_value,
   output logic [HW-1:0]    rsp_slope,
   output logic [HW-1:0]    rsp_curvature,
   output logic [HW-1:0]    rsp_third_deriv,
   output logic             rsp_overflow,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [IDX_W-1:0] csr_index,
   input  logic [CW-1:0]    csr_data
);

   logic                                adv;
   logic [COEF_COUNT-1:0][CW-1:0]       coef_ff;
   bundle_type                          bnd [NUM_TERMS];
   bundle_type                          entry_in;
   bundle_type                          last;

   logic [3:0][COEF_COUNT-1:0][HW-1:0]  d_in;
   logic [3:0][COEF_COUNT-1:0]          dov_in;
   logic [3:0][COEF_COUNT-1:0][HW-1:0]  d_ff;
   logic                                dv_ff;
   logic                                dovf_ff;

   logic [3:0][COEF_COUNT-1:0][WIDE_W-1:0] prod;
   logic [1:0]                          mv_ff;
   logic [1:0]                          mov_ff;
   logic [3:0][3:0][WIDE_W-1:0]         s1_ff;
   logic [3:0][1:0][WIDE_W-1:0]         s2_ff;
   logic                                s1v_ff, s1o_ff, s2v_ff, s2o_ff;
   sat_type                             fin [4];

   logic                                rsp_valid_ff, rsp_overflow_ff;
   logic [3:0][HW-1:0]                  res_ff;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else if (csr_valid && csr_ready && (csr_index < IDX_W'(COEF_COUNT))) begin
         coef_ff[csr_index[$clog2(COEF_COUNT)-1:0]] <= csr_data;
      end
   end

   always_comb begin
      entry_in       = '0;
      entry_in.valid = req_valid;
      entry_in.x     = req_x_point;
      entry_in.h[0]  = HW'(64'h1_0000_0000);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bnd[0] <= '0;
      end else if (adv) begin
         bnd[0] <= entry_in;
      end
   end

   for (genvar k = 1; k < NUM_TERMS; k++) begin : g_term
      logic [WIDE_W-1:0]         tprod;
      bundle_type                d1_ff, d2_ff;
      bundle_type                nxt_in;
      logic signed [WIDE_W-1:0]  t_in;
      sat_type                   s;

      hsw_wmul u_mul (
         .clock (clock),
         .en    (adv),
         .a     (bnd[k-1].h[k-1]),
         .b     (bnd[k-1].x),
         .p_ff  (tprod)
      );

      if (k >= 2) begin : g_sub
         assign t_in = ($signed(tprod) >>> H_SHIFT)
                     - $signed(WIDE_W'($signed(d2_ff.h[k-2]))) * WIDE_W'(2 * (k - 1));
      end else begin : g_nosub
         assign t_in = $signed(tprod) >>> H_SHIFT;
      end

      assign s = sat64(t_in);

      always_comb begin
         nxt_in      = d2_ff;
         nxt_in.h[k] = s.val;
         nxt_in.ov   = d2_ff.ov | s.ov;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d1_ff  <= '0;
            d2_ff  <= '0;
            bnd[k] <= '0;
         end else if (adv) begin
            d1_ff  <= bnd[k-1];
            d2_ff  <= d1_ff;
            bnd[k] <= nxt_in;
         end
      end
   end

   assign last = bnd[NUM_TERMS-1];

   for (genvar q = 0; q < 4; q++) begin : g_dq
      for (genvar k = 0; k < COEF_COUNT; k++) begin : g_dk
         if (k >= NUM_TERMS || k < q) begin : g_zero
            assign d_in[q][k]   = '0;
            assign dov_in[q][k] = 1'b0;
         end else if (q == 0) begin : g_val
            assign d_in[q][k]   = last.h[k];
            assign dov_in[q][k] = 1'b0;
         end else begin : g_der
            sat_type ds;
            assign ds = sat64($signed(WIDE_W'($signed(last.h[k-q])))
                              * WIDE_W'(deriv_mult(q, k)));
            assign d_in[q][k]   = ds.val;
            assign dov_in[q][k] = ds.ov;
         end
         hsw_wmul u_cmul (
            .clock (clock),
            .en    (adv),
            .a     (d_ff[q][k]),
            .b     (coef_ff[k]),
            .p_ff  (prod[q][k])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff   <= 1'b0;
         dovf_ff <= 1'b0;
         mv_ff   <= '0;
         mov_ff  <= '0;
         s1v_ff  <= 1'b0;
         s1o_ff  <= 1'b0;
         s2v_ff  <= 1'b0;
         s2o_ff  <= 1'b0;
      end else if (adv) begin
         dv_ff   <= last.valid;
         dovf_ff <= last.ov | (|dov_in);
         mv_ff   <= {mv_ff[0], dv_ff};
         mov_ff  <= {mov_ff[0], dovf_ff};
         s1v_ff  <= mv_ff[1];
         s1o_ff  <= mov_ff[1];
         s2v_ff  <= s1v_ff;
         s2o_ff  <= s1o_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff <= d_in;
         for (int q = 0; q < 4; q++) begin
            for (int j = 0; j < 4; j++) begin
               s1_ff[q][j] <= ($signed(prod[q][2*j]) >>> C_SHIFT)
                            + ($signed(prod[q][2*j+1]) >>> C_SHIFT);
            end
            for (int j = 0; j < 2; j++) begin
               s2_ff[q][j] <= s1_ff[q][2*j] + s1_ff[q][2*j+1];
            end
         end
      end
   end

   for (genvar q = 0; q < 4; q++) begin : g_fin
      assign fin[q] = sat64($signed(s2_ff[q][0] + s2_ff[q][1]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         rsp_overflow_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff    <= s2v_ff;
         rsp_overflow_ff <= s2o_ff | fin[0].ov | fin[1].ov | fin[2].ov | fin[3].ov;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff[0] <= fin[0].val;
         res_ff[1] <= fin[1].val;
         res_ff[2] <= fin[2].val;
         res_ff[3] <= fin[3].val;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_overflow    = rsp_overflow_ff;
   assign rsp_value       = res_ff[0];
   assign rsp_slope       = res_ff[1];
   assign rsp_curvature   = res_ff[2];
   assign rsp_third_deriv = res_ff[3];

   a_stall_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid_ff && rsp_stall))
      else $error("Input stall does not match the held output beat.");

   a_entry_valid: assert property (@(posedge clock) disable iff (reset)
      adv && req_valid |=> bnd[0].valid)
      else $error("Accepted beat did not enter the pipeline.");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      adv && !req_valid |=> !bnd[0].valid)
      else $error("Pipeline entry became valid without an input beat.");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(res_ff) && $stable(dv_ff) && $stable(s2v_ff))
      else $error("Pipeline moved while the output was stalled.");

endmodule
